// ===== rtl/core/capsule_capsule_overlap_test_defines.svh =====
// Assertion macros for the capsule overlap test block.
`ifndef CAPSULE_CAPSULE_OVERLAP_TEST_DEFINES_SVH
`define CAPSULE_CAPSULE_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CCOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CCOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ccot_pkg.sv =====
// Shared constants and transaction types for the capsule overlap test.
package ccot_pkg;

  localparam int COORD_WIDTH    = 20;
  localparam int PARAM_FRACTION = 16;
  localparam int RADIUS_WIDTH   = 16;
  localparam int DIST_WIDTH     = 42;

  localparam logic [PARAM_FRACTION:0] PARAM_ONE = {1'b1, {PARAM_FRACTION{1'b0}}};

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_TEST  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                            command;
    logic signed [COORD_WIDTH-1:0]   end_a_x;
    logic signed [COORD_WIDTH-1:0]   end_a_y;
    logic signed [COORD_WIDTH-1:0]   end_a_z;
    logic signed [COORD_WIDTH-1:0]   end_b_x;
    logic signed [COORD_WIDTH-1:0]   end_b_y;
    logic signed [COORD_WIDTH-1:0]   end_b_z;
    logic [RADIUS_WIDTH-1:0]         radius;
  } item_t;

  typedef struct packed {
    logic                            hit;
    logic [DIST_WIDTH-1:0]           dist_sq;
    logic [PARAM_FRACTION:0]         seg1_param;
    logic [PARAM_FRACTION:0]         seg2_param;
    logic signed [COORD_WIDTH-1:0]   point1_x;
    logic signed [COORD_WIDTH-1:0]   point1_y;
    logic signed [COORD_WIDTH-1:0]   point1_z;
    logic signed [COORD_WIDTH-1:0]   point2_x;
    logic signed [COORD_WIDTH-1:0]   point2_y;
    logic signed [COORD_WIDTH-1:0]   point2_z;
  } result_t;

endpackage

// ===== rtl/core/ccot_fdiv.sv =====
// Pipelined clamped fraction divider: q = clamp(num/den, 0, 1) in Q1.F.
module ccot_fdiv
  import ccot_pkg::*;
#(
  parameter int NW = 90,
  parameter int F  = PARAM_FRACTION,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  input  logic [SW-1:0]        side,
  output logic                 out_vld,
  output logic [F:0]           q,
  output logic [SW-1:0]        side_out
);

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic          vld  [F+1];
  logic          spec [F+1];
  logic [NW-1:0] rem  [F+1];
  logic [NW-1:0] dv   [F+1];
  logic [F:0]    qq   [F+1];
  logic [SW-1:0] sd   [F+1];

  // entry stage: settle the clamped cases
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      sd[0]  <= side;
      if (num[NW-1] || num == '0) begin
        spec[0] <= 1'b1;
        qq[0]   <= '0;
      end else if (num >= den) begin
        spec[0] <= 1'b1;
        qq[0]   <= ONE;
      end else begin
        spec[0] <= 1'b0;
        qq[0]   <= '0;
      end
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [NW:0] r2;
    logic        ge;
    assign r2 = {rem[k-1], 1'b0};
    assign ge = r2 >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        spec[k] <= spec[k-1];
        dv[k]   <= dv[k-1];
        sd[k]   <= sd[k-1];
        if (ge) begin
          rem[k] <= NW'(r2 - {1'b0, dv[k-1]});
        end else begin
          rem[k] <= r2[NW-1:0];
        end
        if (spec[k-1]) begin
          qq[k] <= qq[k-1];
        end else begin
          qq[k] <= {qq[k-1][F-1:0], ge};
        end
      end
    end
  end

  assign out_vld  = vld[F];
  assign q        = qq[F];
  assign side_out = sd[F];

endmodule

// ===== rtl/core/capsule_capsule_overlap_test.sv =====
// Top level of the capsule overlap test: reference store and test pipeline.
//
// Usage:
//   item / item_valid / item_ready carry one transaction per accepted edge.
//   command CMD_STORE loads the reference capsule (segment ends and radius)
//   and produces no result. command CMD_TEST checks the candidate capsule
//   against the reference held at the time it is accepted.
//   result / result_valid / result_ready return one transaction per test:
//   s and t on the two segments, both closest points, squared distance, hit.
//   Each test passes through the two bit-per-stage dividers in series.
//   Throughput is one transaction per cycle while the output is not stalled;
//   a store may follow or precede a test back to back and tests already in
//   flight keep their old reference.
//   Reset clears the reference capsule to zero and empties the pipeline.
//   When the receiver holds result_ready low with a result waiting, the whole
//   pipeline freezes and item_ready drops; nothing is lost or repeated.
//
module capsule_capsule_overlap_test
  import ccot_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  `include "capsule_capsule_overlap_test_defines.svh"

  localparam int CW = COORD_WIDTH;
  localparam int F  = PARAM_FRACTION;
  localparam int RW = RADIUS_WIDTH;
  localparam int DW = 2 * CW + 4;   // dot product width
  localparam int HW = DW / 2;       // split point for the products of dots
  localparam int PW = 2 * DW + 2;   // divider operand width
  localparam int MW = CW + F + 3;   // lerp product width
  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (F - 1);

  // which parameter the second divider produces
  typedef enum logic [1:0] {
    ROUTE_NONE,
    ROUTE_T,
    ROUTE_S
  } route_t;

  // everything a test carries down the pipe
  typedef struct packed {
    logic [2:0][CW-1:0]     p2;
    logic [2:0][CW-1:0]     a0;
    logic [2:0][CW:0]       d1;
    logic [2:0][CW:0]       d2;
    logic [2:0][CW:0]       r;
    logic [DW-1:0]          a;
    logic [DW-1:0]          e;
    logic [DW-1:0]          f;
    logic [DW-1:0]          c;
    logic [DW-1:0]          b;
    logic [RW:0]            rsum;
    logic                   az;
    logic                   ez;
    logic [2*DW-1:0]        ae;
    logic [2*DW-1:0]        bb;
    logic [2*DW-1:0]        bf;
    logic [2*DW-1:0]        ce;
    logic [DW+F+1:0]        bs;
    logic [F:0]             s;
    logic [F:0]             t;
    route_t                 route;
    logic [2:0][MW-1:0]     m1;
    logic [2:0][MW-1:0]     m2;
    logic [2:0][CW-1:0]     c1;
    logic [2:0][CW-1:0]     c2;
    logic [2:0][2*CW+1:0]   sq;
    logic [2*RW+1:0]        rsq;
  } pipe_t;

  localparam int SW = $bits(pipe_t);

  function automatic logic signed [DW-1:0] dot3(input logic [2:0][CW:0] x,
                                                input logic [2:0][CW:0] y);
    logic signed [2*CW+1:0] m;
    logic signed [DW-1:0]   acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      m   = $signed(x[k]) * $signed(y[k]);
      acc = acc + DW'(m);
    end
    return acc;
  endfunction

  // global advance: the output register is free or being drained
  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // reference capsule
  logic signed [CW-1:0] ref_a [3];
  logic signed [CW-1:0] ref_b [3];
  logic [RW-1:0]        ref_rad;

  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  assign pa[0] = item.end_a_x;
  assign pa[1] = item.end_a_y;
  assign pa[2] = item.end_a_z;
  assign pb[0] = item.end_b_x;
  assign pb[1] = item.end_b_y;
  assign pb[2] = item.end_b_z;

  logic take;
  assign take = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ref_a[i] <= '0;
        ref_b[i] <= '0;
      end
      ref_rad <= '0;
    end else if (take && item.command == CMD_STORE) begin
      for (int i = 0; i < 3; i++) begin
        ref_a[i] <= pa[i];
        ref_b[i] <= pb[i];
      end
      ref_rad <= item.radius;
    end
  end

  pipe_t s1, s1_next, s2, s2_next, s3, s3_next, s4, s4_next, s5, s5_next;
  pipe_t s7, s7_next, s8, s8_next, s9, s9_next;
  logic  v1, v2, v3, v4, v5, v7, v8, v9;

  // stage 1: edge vectors, relative offset, radius sum
  always_comb begin
    s1_next = '0;
    for (int i = 0; i < 3; i++) begin
      s1_next.p2[i] = pa[i];
      s1_next.a0[i] = ref_a[i];
      s1_next.d1[i] = (CW+1)'(ref_b[i]) - (CW+1)'(ref_a[i]);
      s1_next.d2[i] = (CW+1)'(pb[i]) - (CW+1)'(pa[i]);
      s1_next.r[i]  = (CW+1)'(ref_a[i]) - (CW+1)'(pa[i]);
    end
    s1_next.rsum = (RW+1)'(ref_rad) + (RW+1)'(item.radius);
  end

  // stage 2: dot products
  always_comb begin
    s2_next   = s1;
    s2_next.a = dot3(s1.d1, s1.d1);
    s2_next.e = dot3(s1.d2, s1.d2);
    s2_next.f = dot3(s1.d2, s1.r);
    s2_next.c = dot3(s1.d1, s1.r);
    s2_next.b = dot3(s1.d1, s1.d2);
  end

  // stage 3: zero tests; products of dots split on the left operand
  logic signed [DW+HW:0]   ae_lo, bb_lo, bf_lo, ce_lo;
  logic signed [DW+HW-1:0] ae_hi, bb_hi, bf_hi, ce_hi;
  always_comb begin
    s3_next    = s2;
    s3_next.az = (s2.a == '0);
    s3_next.ez = (s2.e == '0);
  end

  // stage 4: recombine the partial products
  always_comb begin
    s4_next    = s3;
    s4_next.ae = ((2*DW)'(ae_hi) <<< HW) + (2*DW)'(ae_lo);
    s4_next.bb = ((2*DW)'(bb_hi) <<< HW) + (2*DW)'(bb_lo);
    s4_next.bf = ((2*DW)'(bf_hi) <<< HW) + (2*DW)'(bf_lo);
    s4_next.ce = ((2*DW)'(ce_hi) <<< HW) + (2*DW)'(ce_lo);
  end

  // first divider: s = (bf - ce) / (ae - bb), general case only
  logic signed [PW-1:0] denom, snum, num1, den1;
  logic                 go1;
  always_comb begin
    denom = PW'($signed(s4.ae)) - PW'($signed(s4.bb));
    snum  = PW'($signed(s4.bf)) - PW'($signed(s4.ce));
    go1   = !s4.az && !s4.ez && (denom != '0);
    num1  = go1 ? snum : '0;
    den1  = go1 ? denom : PW'(1);
  end

  logic          d1_vld;
  logic [F:0]    q1;
  logic [SW-1:0] d1_side;

  ccot_fdiv #(.NW(PW), .F(F), .SW(SW)) u_div_s (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v4),
    .num      (num1),
    .den      (den1),
    .side     (s4),
    .out_vld  (d1_vld),
    .q        (q1),
    .side_out (d1_side)
  );

  // stage 5: b * s for the t numerator
  always_comb begin
    s5_next    = pipe_t'(d1_side);
    s5_next.s  = q1;
    s5_next.bs = $signed(s5_next.b) * $signed({1'b0, q1});
  end

  // second divider: pick t, or recompute s after clamping t
  logic signed [PW-1:0] tn, td, negc, bmc, num2, den2;
  pipe_t                side2;
  always_comb begin
    tn    = PW'($signed(s5.bs)) + (PW'($signed(s5.f)) <<< F);
    td    = PW'($signed(s5.e)) <<< F;
    negc  = -PW'($signed(s5.c));
    bmc   = PW'($signed(s5.b)) - PW'($signed(s5.c));
    side2 = s5;
    num2  = '0;
    den2  = PW'(1);
    side2.route = ROUTE_NONE;
    if (s5.az && s5.ez) begin
      side2.s = '0;
      side2.t = '0;
    end else if (s5.az) begin
      side2.s     = '0;
      side2.t     = '0;
      side2.route = ROUTE_T;
      num2        = PW'($signed(s5.f));
      den2        = PW'($signed(s5.e));
    end else if (s5.ez) begin
      side2.t     = '0;
      side2.route = ROUTE_S;
      num2        = negc;
      den2        = PW'($signed(s5.a));
    end else if (tn < 0) begin
      side2.t     = '0;
      side2.route = ROUTE_S;
      num2        = negc;
      den2        = PW'($signed(s5.a));
    end else if (tn > td) begin
      side2.t     = PARAM_ONE;
      side2.route = ROUTE_S;
      num2        = bmc;
      den2        = PW'($signed(s5.a));
    end else begin
      side2.route = ROUTE_T;
      num2        = tn;
      den2        = td;
    end
  end

  logic          d2_vld;
  logic [F:0]    q2;
  logic [SW-1:0] d2_side;

  ccot_fdiv #(.NW(PW), .F(F), .SW(SW)) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v5),
    .num      (num2),
    .den      (den2),
    .side     (side2),
    .out_vld  (d2_vld),
    .q        (q2),
    .side_out (d2_side)
  );

  // stage 7: final s and t, edge times parameter
  always_comb begin
    s7_next = pipe_t'(d2_side);
    case (s7_next.route)
      ROUTE_T: s7_next.t = q2;
      ROUTE_S: s7_next.s = q2;
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      s7_next.m1[i] = $signed(s7_next.d1[i]) * $signed({1'b0, s7_next.s});
      s7_next.m2[i] = $signed(s7_next.d2[i]) * $signed({1'b0, s7_next.t});
    end
  end

  // stage 8: rounded closest points
  logic signed [MW-1:0] t1 [3];
  logic signed [MW-1:0] t2 [3];
  always_comb begin
    s8_next = s7;
    for (int i = 0; i < 3; i++) begin
      t1[i] = $signed(s7.m1[i]) + HALF;
      t2[i] = $signed(s7.m2[i]) + HALF;
      s8_next.c1[i] = s7.a0[i] + CW'(t1[i] >>> F);
      s8_next.c2[i] = s7.p2[i] + CW'(t2[i] >>> F);
    end
  end

  // stage 9: squared component gaps and squared radius sum
  logic signed [CW:0] dd [3];
  always_comb begin
    s9_next = s8;
    for (int i = 0; i < 3; i++) begin
      dd[i] = (CW+1)'($signed(s8.c1[i])) - (CW+1)'($signed(s8.c2[i]));
      s9_next.sq[i] = dd[i] * dd[i];
    end
    s9_next.rsq = s8.rsum * s8.rsum;
  end

  // output stage: distance sum and hit
  logic [DW-1:0] dist_sum;
  result_t       result_next;
  always_comb begin
    dist_sum = DW'(s9.sq[0]) + DW'(s9.sq[1]) + DW'(s9.sq[2]);
    result_next.hit        = dist_sum <= DW'(s9.rsq);
    result_next.dist_sq    = DIST_WIDTH'(dist_sum);
    result_next.seg1_param = s9.s;
    result_next.seg2_param = s9.t;
    result_next.point1_x   = s9.c1[0];
    result_next.point1_y   = s9.c1[1];
    result_next.point1_z   = s9.c1[2];
    result_next.point2_x   = s9.c2[0];
    result_next.point2_y   = s9.c2[1];
    result_next.point2_z   = s9.c2[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      v7           <= 1'b0;
      v8           <= 1'b0;
      v9           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= take && item.command == CMD_TEST;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      v5           <= d1_vld;
      v7           <= d2_vld;
      v8           <= v7;
      v9           <= v8;
      result_valid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1     <= s1_next;
      s2     <= s2_next;
      s3     <= s3_next;
      ae_lo  <= $signed({1'b0, s2.a[HW-1:0]}) * $signed(s2.e);
      ae_hi  <= $signed(s2.a[DW-1:HW]) * $signed(s2.e);
      bb_lo  <= $signed({1'b0, s2.b[HW-1:0]}) * $signed(s2.b);
      bb_hi  <= $signed(s2.b[DW-1:HW]) * $signed(s2.b);
      bf_lo  <= $signed({1'b0, s2.b[HW-1:0]}) * $signed(s2.f);
      bf_hi  <= $signed(s2.b[DW-1:HW]) * $signed(s2.f);
      ce_lo  <= $signed({1'b0, s2.c[HW-1:0]}) * $signed(s2.e);
      ce_hi  <= $signed(s2.c[DW-1:HW]) * $signed(s2.e);
      s4     <= s4_next;
      s5     <= s5_next;
      s7     <= s7_next;
      s8     <= s8_next;
      s9     <= s9_next;
      result <= result_next;
    end
  end

  `CCOT_ASSERT_NEXT(a_store_silent, take && item.command == CMD_STORE, !v1, "store in test pipe")
  `CCOT_ASSERT_NOW(a_s_range, result_valid, result.seg1_param <= PARAM_ONE, "s above one")
  `CCOT_ASSERT_NOW(a_t_range, result_valid, result.seg2_param <= PARAM_ONE, "t above one")
  `CCOT_ASSERT_NEXT(a_stall_hold, !en, $stable(v9) && $stable(s9) && $stable(v1), "moved in stall")

endmodule
